// ----- rtl/core/stl_pkg.sv -----
// Shared types, codes and the single-pass lexer step function for the token lexer.
package stl_pkg;

    // Lexer mode, one-hot
    typedef enum logic [7:0] {
        MODE_START = 8'b0000_0001,
        MODE_WORD  = 8'b0000_0010,
        MODE_DIGIT = 8'b0000_0100,
        MODE_STR   = 8'b0000_1000,
        MODE_AND   = 8'b0001_0000,
        MODE_MERG  = 8'b0010_0000,
        MODE_PIPE  = 8'b0100_0000,
        MODE_RARR  = 8'b1000_0000
    } mode_t;

    // Token kinds
    localparam logic [3:0] TK_NONE      = 4'd0;
    localparam logic [3:0] TK_ENDFILE   = 4'd0;
    localparam logic [3:0] TK_NEWLINE   = 4'd1;
    localparam logic [3:0] TK_SEMI      = 4'd2;
    localparam logic [3:0] TK_STR       = 4'd3;
    localparam logic [3:0] TK_AND       = 4'd4;
    localparam logic [3:0] TK_OR        = 4'd5;
    localparam logic [3:0] TK_PIPE      = 4'd6;
    localparam logic [3:0] TK_NOT       = 4'd7;
    localparam logic [3:0] TK_LPAREN    = 4'd8;
    localparam logic [3:0] TK_RPAREN    = 4'd9;
    localparam logic [3:0] TK_STDIN     = 4'd10;
    localparam logic [3:0] TK_OVR       = 4'd11;
    localparam logic [3:0] TK_APND      = 4'd12;
    localparam logic [3:0] TK_MERG_OUT  = 4'd13;
    localparam logic [3:0] TK_MERG_APND = 4'd14;
    localparam logic [3:0] TK_CMD       = 4'd15;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNTERM  = 2'd1;
    localparam logic [1:0] ERR_BAD_AMP = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    // One result transaction without the last flag
    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       token_end;
        logic [3:0] token_kind;
        logic [1:0] error_code;
    } res_t;

    // Outcome of one pass through the mode logic
    typedef struct packed {
        logic  emit;
        res_t  res;
        mode_t nxt;
        logic  again;
    } pass_t;

    // Queue entry: all results caused by one input
    typedef struct packed {
        logic two_res;
        res_t r0;
        res_t r1;
    } ent_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic ends_word(logic [7:0] c);
        logic hit;
        case (c)
            CH_AMP, CH_PIPE, CH_BANG, CH_LT, CH_GT, CH_DQUOTE, CH_SQUOTE,
            CH_SEMI, CH_COLON, CH_LPAREN, CH_RPAREN, CH_CARET, CH_PCT,
            CH_DOLLAR, CH_HASH: hit = 1'b1;
            default:            hit = is_space(c);
        endcase
        return hit;
    endfunction

    function automatic res_t mk_res(logic cv, logic [7:0] ch, logic te,
                                    logic [3:0] kind, logic [1:0] err);
        res_t r;
        r.char_valid = cv;
        r.out_char   = cv ? ch : 8'h00;
        r.token_end  = te;
        r.token_kind = te ? kind : TK_NONE;
        r.error_code = err;
        return r;
    endfunction

    // One step of the lexer in a given mode
    function automatic pass_t lex_pass(mode_t mode, logic [7:0] c, logic eof);
        pass_t p;
        p       = '0;
        p.nxt   = mode;
        case (mode)
            MODE_START:
            begin
                if (eof)
                begin
                    p.emit = 1'b1;
                    p.res  = mk_res(1'b0, c, 1'b1, TK_ENDFILE, ERR_NONE);
                end
                else if (c != CH_LF && is_space(c))
                begin
                    p.emit = 1'b0;
                end
                else if (is_digit(c))
                begin
                    p.nxt  = MODE_DIGIT;
                    p.emit = 1'b1;
                    p.res  = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
                else
                begin
                    p.emit = 1'b1;
                    case (c)
                        CH_NUL, CH_LF:
                            p.res = mk_res(1'b1, c, 1'b1, TK_NEWLINE, ERR_NONE);
                        CH_SEMI:
                            p.res = mk_res(1'b1, c, 1'b1, TK_SEMI, ERR_NONE);
                        CH_DQUOTE:
                        begin
                            p.nxt  = MODE_STR;
                            p.emit = 1'b0;
                        end
                        CH_AMP:
                        begin
                            p.nxt = MODE_AND;
                            p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                        end
                        CH_PIPE:
                        begin
                            p.nxt = MODE_PIPE;
                            p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                        end
                        CH_LT:
                            p.res = mk_res(1'b1, c, 1'b1, TK_STDIN, ERR_NONE);
                        CH_BANG:
                            p.res = mk_res(1'b1, c, 1'b1, TK_NOT, ERR_NONE);
                        CH_GT:
                        begin
                            p.nxt = MODE_RARR;
                            p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                        end
                        CH_LPAREN:
                            p.res = mk_res(1'b1, c, 1'b1, TK_LPAREN, ERR_NONE);
                        CH_RPAREN:
                            p.res = mk_res(1'b1, c, 1'b1, TK_RPAREN, ERR_NONE);
                        default:
                        begin
                            p.nxt = MODE_WORD;
                            p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                        end
                    endcase
                end
            end
            MODE_WORD:
            begin
                p.emit = 1'b1;
                if (eof || ends_word(c))
                begin
                    p.res   = mk_res(1'b0, c, 1'b1, TK_CMD, ERR_NONE);
                    p.nxt   = MODE_START;
                    p.again = 1'b1;
                end
                else
                begin
                    p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
            end
            MODE_DIGIT:
            begin
                if (eof)
                begin
                    p.nxt   = MODE_WORD;
                    p.again = 1'b1;
                end
                else if (c == CH_GT)
                begin
                    p.nxt  = MODE_RARR;
                    p.emit = 1'b1;
                    p.res  = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
                else if (c == CH_AMP)
                begin
                    p.nxt  = MODE_AND;
                    p.emit = 1'b1;
                    p.res  = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
                else if (is_digit(c))
                begin
                    p.emit = 1'b1;
                    p.res  = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
                else
                begin
                    p.nxt   = MODE_WORD;
                    p.again = 1'b1;
                end
            end
            MODE_STR:
            begin
                p.emit = 1'b1;
                if (eof || c == CH_LF)
                begin
                    p.res = mk_res(1'b0, c, 1'b0, TK_NONE, ERR_UNTERM);
                    p.nxt = MODE_START;
                end
                else if (c == CH_DQUOTE)
                begin
                    p.res = mk_res(1'b0, c, 1'b1, TK_STR, ERR_NONE);
                    p.nxt = MODE_START;
                end
                else
                begin
                    p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                end
            end
            MODE_AND:
            begin
                p.emit = 1'b1;
                if (!eof && c == CH_AMP)
                begin
                    p.res = mk_res(1'b1, c, 1'b1, TK_AND, ERR_NONE);
                    p.nxt = MODE_START;
                end
                else if (!eof && c == CH_GT)
                begin
                    p.res = mk_res(1'b1, c, 1'b0, TK_NONE, ERR_NONE);
                    p.nxt = MODE_MERG;
                end
                else
                begin
                    p.res = mk_res(1'b0, c, 1'b0, TK_NONE, ERR_BAD_AMP);
                    p.nxt = MODE_START;
                end
            end
            MODE_MERG:
            begin
                p.emit = 1'b1;
                p.nxt  = MODE_START;
                if (!eof && c == CH_GT)
                begin
                    p.res = mk_res(1'b1, c, 1'b1, TK_MERG_APND, ERR_NONE);
                end
                else
                begin
                    p.res   = mk_res(1'b0, c, 1'b1, TK_MERG_OUT, ERR_NONE);
                    p.again = 1'b1;
                end
            end
            MODE_PIPE:
            begin
                p.emit = 1'b1;
                p.nxt  = MODE_START;
                if (!eof && c == CH_PIPE)
                begin
                    p.res = mk_res(1'b1, c, 1'b1, TK_OR, ERR_NONE);
                end
                else
                begin
                    p.res   = mk_res(1'b0, c, 1'b1, TK_PIPE, ERR_NONE);
                    p.again = 1'b1;
                end
            end
            MODE_RARR:
            begin
                p.emit = 1'b1;
                p.nxt  = MODE_START;
                if (!eof && c == CH_GT)
                begin
                    p.res = mk_res(1'b1, c, 1'b1, TK_APND, ERR_NONE);
                end
                else
                begin
                    p.res   = mk_res(1'b0, c, 1'b1, TK_OVR, ERR_NONE);
                    p.again = 1'b1;
                end
            end
            default:
            begin
                p.nxt = MODE_START;
            end
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/core/stl_in_if.sv -----
// Character input channel: one byte or end-of-file mark per transaction.
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_file;

    modport source (output valid, output char_in, output end_of_file, input ready);
    modport sink   (input valid, input char_in, input end_of_file, output ready);
endinterface

// ----- rtl/core/stl_out_if.sv -----
// Token output channel: one text character and/or token end per transaction.
interface stl_out_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] out_char;
    logic       token_end;
    logic [3:0] token_kind;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output char_valid, output out_char, output token_end,
                    output token_kind, output error_code, output last, input ready);
    modport sink   (input valid, input char_valid, input out_char, input token_end,
                    input token_kind, input error_code, input last, output ready);
endinterface

// ----- rtl/core/shell_token_lexer_unit.sv -----
// Top level of the shell token lexer.
//
// char_stream (sink) takes one transaction per input byte, or an end-of-file
// mark with end_of_file high. token_stream (source) gives one or two result
// transactions per input: a text character, a token end with its kind, or an
// error; last marks the final result of an input. Whitespace in start mode and
// an opening quote give no result at all.
//
// The front end classifies a byte in the cycle it is accepted and writes all of
// its results into a two-entry queue; the back end drains one result a cycle
// while the receiver is ready. An accepted input is held in a queue entry and
// then in the back end's current-entry register before its first result shows
// on token_stream. Throughput: one result per cycle while the receiver is ready;
// an input that ends a token and starts or forms another gives two results, and
// the output drain is the limit.
// Reset returns the lexer to its start mode and empties the queue. When the
// receiver stalls, the current result holds; the queue fills and char_stream
// drops ready only once both entries are taken.
module shell_token_lexer_unit
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    stl_in_if.sink     char_stream,
    stl_out_if.source  token_stream
);

    logic q_full;
    logic push;
    ent_t push_ent;
    logic q_pop;
    logic q_valid;
    ent_t q_ent;

    stl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (char_stream),
        .q_full   (q_full),
        .push     (push),
        .push_ent (push_ent)
    );

    stl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_ent  (q_ent)
    );

    stl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ent   (q_ent),
        .q_pop   (q_pop),
        .out_ch  (token_stream)
    );

endmodule

// ----- rtl/core/stl_front.sv -----
// Front end: accepts characters, runs the mode logic, builds one queue entry per input that gives a result.
module stl_front
    import stl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    stl_in_if.sink   in_ch,
    input  logic     q_full,
    output logic     push,
    output ent_t     push_ent
);

    mode_t      mode_reg;
    mode_t      mode_next;
    pass_t      ps [3];
    logic [2:0] used;
    logic [1:0] n_res;
    logic       accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Up to three chained passes: a consumed-less token end, or a number that turns into a word, re-runs the byte
    always_comb
    begin
        ps[0]     = lex_pass(mode_reg, in_ch.char_in, in_ch.end_of_file);
        ps[1]     = lex_pass(ps[0].nxt, in_ch.char_in, in_ch.end_of_file);
        ps[2]     = lex_pass(ps[1].nxt, in_ch.char_in, in_ch.end_of_file);
        used[0]   = 1'b1;
        used[1]   = ps[0].again;
        used[2]   = ps[0].again && ps[1].again;
        n_res     = 2'd0;
        push_ent  = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (used[i] && ps[i].emit)
            begin
                if (n_res == 2'd0)
                begin
                    push_ent.r0 = ps[i].res;
                end
                else
                begin
                    push_ent.r1 = ps[i].res;
                end
                n_res = n_res + 2'd1;
            end
        end
        push_ent.two_res = (n_res == 2'd2);
        if (used[2])
        begin
            mode_next = ps[2].nxt;
        end
        else if (used[1])
        begin
            mode_next = ps[1].nxt;
        end
        else
        begin
            mode_next = ps[0].nxt;
        end
    end

    assign push = accept && (n_res != 2'd0);

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    // A two-result entry always starts with a token end that carries no text
    a_two_first_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_ent.two_res |-> push_ent.r0.token_end && !push_ent.r0.char_valid)
        else $error("two-result entry does not start with a token end");

    // An error drops the input, so nothing follows it
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        push && (push_ent.r0.error_code != ERR_NONE) |-> !push_ent.two_res)
        else $error("error result followed by a second result");

endmodule

// ----- rtl/core/stl_queue.sv -----
// Two-entry queue between the front and back ends.
module stl_queue
    import stl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ent_t push_ent,
    output logic full,
    input  logic pop,
    output logic valid,
    output ent_t pop_ent
);

    ent_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign pop_ent = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    // The count never reaches three, and the pointers differ exactly when one entry is held
    a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd3) && ((cnt_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg)))
        else $error("queue count and pointers disagree");

endmodule

// ----- rtl/core/stl_back.sv -----
// Back end: takes queue entries and hands out their results one per transaction.
module stl_back
    import stl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  ent_t       q_ent,
    output logic       q_pop,
    stl_out_if.source  out_ch
);

    logic cur_valid_reg;
    logic sel_reg;
    ent_t cur_reg;
    res_t res;
    logic is_last;
    logic out_fire;
    logic load;

    assign res     = sel_reg ? cur_reg.r1 : cur_reg.r0;
    assign is_last = sel_reg || !cur_reg.two_res;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign load    = !cur_valid_reg || (out_fire && is_last);
    assign q_pop   = load && q_valid;

    assign out_ch.valid      = cur_valid_reg;
    assign out_ch.char_valid = res.char_valid;
    assign out_ch.out_char   = res.out_char;
    assign out_ch.token_end  = res.token_end;
    assign out_ch.token_kind = res.token_kind;
    assign out_ch.error_code = res.error_code;
    assign out_ch.last       = is_last;

    // Entry valid and result select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= q_valid;
            sel_reg       <= 1'b0;
        end
        else if (out_fire)
        begin
            sel_reg <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_ent;
        end
    end

    // The second result of an entry follows the first
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_ch.last |=> out_ch.valid && out_ch.last)
        else $error("second result of an entry lost");

endmodule
